// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the running gait trajectory RTL.
// Self-contained; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define RGFT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rgft: property violated");
// Expression must never be true outside reset.
`define RGFT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("rgft: forbidden condition seen");
`else
`define RGFT_ASSERT(lbl, clk, rst, prop)
`define RGFT_NEVER(lbl, clk, rst, expr)
`endif

`endif

// ----- hw/rtl/rgft_pkg.sv -----
// Shared constants, types and the quarter-wave sine table for the
// running gait foot trajectory block. No dependencies.
`default_nettype none

package rgft_pkg;

  localparam int LEG_COUNT   = 6;
  localparam int LEG_W       = 3;
  localparam int PHASE_W     = 16;
  localparam int FRAC_W      = 16;
  localparam int LEN_W       = 15;
  localparam int STEP_W      = 16;
  localparam int NUM_W       = 16;
  localparam int PROD_W      = 30;
  localparam int QUO_W       = LEN_W;
  localparam int ANG_W       = 10;
  localparam int ANG_REM_W   = LEN_W + ANG_W;
  localparam int SINE_W      = 15;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;
  localparam int REG_IDX_W   = 2;

  localparam logic [FRAC_W-1:0] HALF_TURN = 16'h8000;

  // register map, index = paddr / 4
  localparam logic [REG_IDX_W-1:0] REG_FLIGHT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_STEP   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LIFT   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_MASK   = 2'd3;

  localparam logic [FRAC_W-1:0]    FLIGHT_RESET = 16'd4915;
  localparam logic [LEN_W-1:0]     STEP_RESET   = 15'd0;
  localparam logic [LEN_W-1:0]     LIFT_RESET   = 15'd0;
  localparam logic [LEG_COUNT-1:0] MASK_RESET   = LEG_COUNT'(21);

  localparam logic [SINE_W-1:0] SINE_PEAK = 15'd32767;

  localparam logic [SINE_W-1:0] QUARTER_SINE [17] = '{
    15'd0,     15'd3212,  15'd6393,  15'd9512,  15'd12539, 15'd15446,
    15'd18204, 15'd20787, 15'd23170, 15'd25329, 15'd27245, 15'd28898,
    15'd30273, 15'd31356, 15'd32137, 15'd32609, 15'd32767
  };

  // word carried through the divider stages
  typedef struct packed {
    logic                 flight;
    logic                 neg;
    logic [NUM_W-1:0]     den;
    logic [PROD_W-1:0]    rem_s;
    logic [QUO_W-1:0]     quo_s;
    logic [FRAC_W-1:0]    fl;
    logic [ANG_REM_W-1:0] rem_a;
    logic [ANG_W-1:0]     quo_a;
  } div_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rgft_front.sv -----
// Front end: leg grouping, phase decode, ramp operands and the step product.
// Two register stages; depends on rgft_pkg.
`default_nettype none

module rgft_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              query_valid,
  input  wire logic [rgft_pkg::LEG_W-1:0]        leg_index,
  input  wire logic [rgft_pkg::PHASE_W-1:0]      gait_phase,
  input  wire logic [rgft_pkg::FRAC_W-1:0]       flight_share,
  input  wire logic [rgft_pkg::LEN_W-1:0]        step_length,
  input  wire logic [rgft_pkg::LEG_COUNT-1:0]    group_a_mask,
  output logic                                   div_valid,
  output rgft_pkg::div_t                         div_word
);

  typedef struct packed {
    logic                           flight;
    logic                           neg;
    logic [rgft_pkg::NUM_W-1:0]     mag;
    logic [rgft_pkg::NUM_W-1:0]     den;
    logic [rgft_pkg::LEN_W-1:0]     u;
    logic [rgft_pkg::FRAC_W-1:0]    fl;
  } dec_t;

  logic                           in_a;
  logic [rgft_pkg::PHASE_W-1:0]   hp;
  logic [rgft_pkg::LEN_W-1:0]     local_ph;
  logic [rgft_pkg::FRAC_W-1:0]    fl_sat;
  logic [rgft_pkg::FRAC_W-1:0]    sup_end;
  logic [rgft_pkg::NUM_W-1:0]     twice_l;
  logic [rgft_pkg::LEN_W-1:0]     u_val;
  logic [rgft_pkg::NUM_W-1:0]     op_a;
  logic [rgft_pkg::NUM_W-1:0]     op_b;
  dec_t                           dec_next;
  dec_t                           dec;
  logic                           dec_valid;
  logic [rgft_pkg::PROD_W:0]      prod;
  rgft_pkg::div_t                 div_next;

  // legs past the count are never in group A
  always_comb begin
    in_a = 1'b0;
    for (int i = 0; i < rgft_pkg::LEG_COUNT; i++) begin
      if (leg_index == rgft_pkg::LEG_W'(i)) in_a = group_a_mask[i];
    end
  end

  always_comb begin
    hp       = in_a ? gait_phase : {~gait_phase[15], gait_phase[14:0]};
    local_ph = hp[14:0];
    fl_sat   = (flight_share > rgft_pkg::HALF_TURN) ? rgft_pkg::HALF_TURN
                                                     : flight_share;
    sup_end  = rgft_pkg::HALF_TURN - fl_sat;
    twice_l  = {local_ph, 1'b0};
    u_val    = rgft_pkg::LEN_W'({1'b0, local_ph} - sup_end);
    dec_next.u  = u_val;
    dec_next.fl = fl_sat;
    priority if (hp[15]) begin
      op_a            = rgft_pkg::HALF_TURN;
      op_b            = twice_l;
      dec_next.den    = rgft_pkg::HALF_TURN;
      dec_next.flight = 1'b0;
    end else if ({1'b0, local_ph} < sup_end) begin
      op_a            = sup_end;
      op_b            = twice_l;
      dec_next.den    = sup_end;
      dec_next.flight = 1'b0;
    end else begin
      op_a            = {u_val, 1'b0};
      op_b            = fl_sat;
      dec_next.den    = fl_sat;
      dec_next.flight = 1'b1;
    end
    dec_next.neg = op_a < op_b;
    dec_next.mag = dec_next.neg ? (op_b - op_a) : (op_a - op_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
      div_valid <= 1'b0;
    end else if (en) begin
      dec_valid <= query_valid;
      div_valid <= dec_valid;
    end
  end

  always_comb begin
    prod           = (rgft_pkg::PROD_W + 1)'(dec.mag) * (rgft_pkg::PROD_W + 1)'(step_length);
    div_next.flight = dec.flight;
    div_next.neg    = dec.neg;
    div_next.den    = dec.den;
    div_next.rem_s  = prod[rgft_pkg::PROD_W-1:0];
    div_next.quo_s  = '0;
    div_next.fl     = dec.fl;
    div_next.rem_a  = {dec.u, {rgft_pkg::ANG_W{1'b0}}};
    div_next.quo_a  = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec      <= dec_next;
      div_word <= div_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rgft_divider.sv -----
// Pipelined restoring divider: one quotient bit per stage for the step ramp,
// the sine angle quotient rides along in the low stages. Depends on rgft_pkg.
`default_nettype none

module rgft_divider (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid_s,
  input  wire rgft_pkg::div_t in_word,
  output logic                out_valid_s,
  output rgft_pkg::div_t      out_word
);

  logic           stage_v [0:rgft_pkg::QUO_W];
  rgft_pkg::div_t stage_d [0:rgft_pkg::QUO_W];

  assign stage_v[0] = in_valid_s;
  assign stage_d[0] = in_word;

  for (genvar j = 0; j < rgft_pkg::QUO_W; j++) begin : g_stage
    localparam int K = rgft_pkg::QUO_W - 1 - j;

    logic [rgft_pkg::PROD_W-1:0] ds;
    logic                        take_s;
    rgft_pkg::div_t              nd;

    always_comb begin
      nd     = stage_d[j];
      ds     = rgft_pkg::PROD_W'(stage_d[j].den) << K;
      take_s = stage_d[j].rem_s >= ds;
      if (take_s) nd.rem_s = stage_d[j].rem_s - ds;
      nd.quo_s[K] = take_s;
    end

    if (K < rgft_pkg::ANG_W) begin : g_ang
      logic [rgft_pkg::ANG_REM_W-1:0] da;
      logic                           take_a;
      rgft_pkg::div_t                 na;

      always_comb begin
        na     = nd;
        da     = rgft_pkg::ANG_REM_W'(stage_d[j].fl) << K;
        take_a = stage_d[j].rem_a >= da;
        if (take_a) na.rem_a = stage_d[j].rem_a - da;
        na.quo_a[K] = take_a;
      end

      always_ff @(posedge clk) begin
        if (en) stage_d[j+1] <= na;
      end
    end else begin : g_step_only
      always_ff @(posedge clk) begin
        if (en) stage_d[j+1] <= nd;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_v[j+1] <= 1'b0;
      end else if (en) begin
        stage_v[j+1] <= stage_v[j];
      end
    end
  end

  assign out_valid_s = stage_v[rgft_pkg::QUO_W];
  assign out_word    = stage_d[rgft_pkg::QUO_W];

endmodule

`default_nettype wire

// ----- hw/rtl/rgft_lift.sv -----
// Back end: signed step, interpolated half-wave sine and the lift product.
// Two register stages; depends on rgft_pkg for the sine table.
`default_nettype none

module rgft_lift (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              div_valid,
  input  wire rgft_pkg::div_t                    div_word,
  input  wire logic [rgft_pkg::LEN_W-1:0]        lift_height,
  output logic                                   traj_valid,
  output logic signed [rgft_pkg::STEP_W-1:0]     traj_step,
  output logic [rgft_pkg::LEN_W-1:0]             traj_lift
);

  logic [rgft_pkg::ANG_W-1:0]              q_ang;
  logic [3:0]                              idx;
  logic [4:0]                              frac;
  logic [rgft_pkg::SINE_W-1:0]             lo;
  logic [rgft_pkg::SINE_W-1:0]             hi;
  logic [rgft_pkg::SINE_W+4:0]             interp;
  logic [rgft_pkg::SINE_W-1:0]             sine_next;
  logic [rgft_pkg::STEP_W-1:0]             step_next;
  logic                                    sine_valid;
  logic [rgft_pkg::SINE_W-1:0]             sine;
  logic                                    flight;
  logic [rgft_pkg::STEP_W-1:0]             step_mid;
  logic [2*rgft_pkg::LEN_W-1:0]            lift_prod;

  always_comb begin
    // fold the half wave onto the quarter table
    q_ang  = div_word.quo_a[rgft_pkg::ANG_W-1]
           ? rgft_pkg::ANG_W'(11'd1024 - {1'b0, div_word.quo_a})
           : div_word.quo_a;
    idx    = q_ang[8:5];
    frac   = q_ang[4:0];
    lo     = rgft_pkg::QUARTER_SINE[idx];
    hi     = rgft_pkg::QUARTER_SINE[5'({1'b0, idx} + 5'd1)];
    interp = (rgft_pkg::SINE_W + 5)'(hi - lo) * (rgft_pkg::SINE_W + 5)'(frac);
    sine_next = q_ang[9] ? rgft_pkg::SINE_PEAK
                         : rgft_pkg::SINE_W'(lo + interp[rgft_pkg::SINE_W+4:5]);
    step_next = {1'b0, div_word.quo_s};
    if (div_word.neg) step_next = ~step_next + 1'b1;
  end

  assign lift_prod = (2 * rgft_pkg::LEN_W)'(lift_height) * (2 * rgft_pkg::LEN_W)'(sine);

  always_ff @(posedge clk) begin
    if (rst) begin
      sine_valid <= 1'b0;
      traj_valid <= 1'b0;
    end else if (en) begin
      sine_valid <= div_valid;
      traj_valid <= sine_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sine      <= sine_next;
      flight    <= div_word.flight;
      step_mid  <= step_next;
      traj_step <= signed'(step_mid);
      traj_lift <= flight ? lift_prod[2*rgft_pkg::LEN_W-1:rgft_pkg::LEN_W] : '0;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/running_gait_foot_trajectory.sv -----
// Top level: APB register file, the trajectory pipeline and the output buffer.
// Depends on rgft_pkg, rgft_front, rgft_divider, rgft_lift, assert_macros.svh.
//
// Running gait foot trajectory. Give a leg index and a gait phase on the
// query channel and get that leg's signed step offset and lift height on the
// result channel. The block takes one query word per clock while query_ready
// is high; each query passes through two front stages, the first loading at
// the edge that accepts it, a 15-stage divider that retires one quotient bit
// per stage, two sine/lift stages, then the output register. The whole pipeline
// holds while the output register and its skid stage are both full, so
// query_ready only drops under back-pressure.
// Registers (byte address = 4 * index): 0 flight_share, 1 step_length,
// 2 lift_height, 3 group_a_mask. Write them only while no query is in flight.
`default_nettype none
`include "assert_macros.svh"

module running_gait_foot_trajectory (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [rgft_pkg::ADDR_W-1:0]          paddr,
  input  wire logic [rgft_pkg::DATA_W-1:0]          pwdata,
  output logic [rgft_pkg::DATA_W-1:0]               prdata,
  output logic                                      pready,
  input  wire logic                                 query_valid,
  output logic                                      query_ready,
  input  wire logic [rgft_pkg::LEG_W-1:0]           leg_index,
  input  wire logic [rgft_pkg::PHASE_W-1:0]         gait_phase,
  output logic                                      result_valid,
  input  wire logic                                 result_ready,
  output logic signed [rgft_pkg::STEP_W-1:0]        step_offset,
  output logic [rgft_pkg::LEN_W-1:0]                lift_offset
);

  logic [rgft_pkg::FRAC_W-1:0]       flight_share;
  logic [rgft_pkg::LEN_W-1:0]        step_length;
  logic [rgft_pkg::LEN_W-1:0]        lift_height;
  logic [rgft_pkg::LEG_COUNT-1:0]    group_a_mask;
  logic [rgft_pkg::REG_IDX_W-1:0]    reg_idx;
  logic                              cfg_write;

  logic                              en;
  logic                              div_in_valid;
  rgft_pkg::div_t                    div_in_word;
  logic                              div_out_valid;
  rgft_pkg::div_t                    div_out_word;
  logic                              traj_valid;
  logic signed [rgft_pkg::STEP_W-1:0] traj_step;
  logic [rgft_pkg::LEN_W-1:0]        traj_lift;
  logic                              traj_fire;

  logic                              skid_valid;
  logic signed [rgft_pkg::STEP_W-1:0] skid_step;
  logic [rgft_pkg::LEN_W-1:0]        skid_lift;
  logic signed [rgft_pkg::STEP_W-1:0] step_limit;
  logic                              out_stalled;
  logic                              step_ok;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[rgft_pkg::ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      flight_share <= rgft_pkg::FLIGHT_RESET;
      step_length  <= rgft_pkg::STEP_RESET;
      lift_height  <= rgft_pkg::LIFT_RESET;
      group_a_mask <= rgft_pkg::MASK_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        rgft_pkg::REG_FLIGHT: flight_share <= pwdata[rgft_pkg::FRAC_W-1:0];
        rgft_pkg::REG_STEP:   step_length  <= pwdata[rgft_pkg::LEN_W-1:0];
        rgft_pkg::REG_LIFT:   lift_height  <= pwdata[rgft_pkg::LEN_W-1:0];
        rgft_pkg::REG_MASK:   group_a_mask <= pwdata[rgft_pkg::LEG_COUNT-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rgft_pkg::REG_FLIGHT: prdata = rgft_pkg::DATA_W'(flight_share);
      rgft_pkg::REG_STEP:   prdata = rgft_pkg::DATA_W'(step_length);
      rgft_pkg::REG_LIFT:   prdata = rgft_pkg::DATA_W'(lift_height);
      rgft_pkg::REG_MASK:   prdata = rgft_pkg::DATA_W'(group_a_mask);
    endcase
  end

  // advance the whole pipeline unless the skid stage holds a word
  assign en          = !skid_valid;
  assign query_ready = en;

  rgft_front u_front (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .query_valid     (query_valid),
    .leg_index       (leg_index),
    .gait_phase      (gait_phase),
    .flight_share    (flight_share),
    .step_length     (step_length),
    .group_a_mask    (group_a_mask),
    .div_valid       (div_in_valid),
    .div_word        (div_in_word)
  );

  rgft_divider u_divider (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid_s  (div_in_valid),
    .in_word     (div_in_word),
    .out_valid_s (div_out_valid),
    .out_word    (div_out_word)
  );

  rgft_lift u_lift (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .div_valid   (div_out_valid),
    .div_word    (div_out_word),
    .lift_height (lift_height),
    .traj_valid  (traj_valid),
    .traj_step   (traj_step),
    .traj_lift   (traj_lift)
  );

  assign traj_fire = en && traj_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || result_ready) begin
      // output register frees up: drain skid first
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= traj_fire;
      end
    end else if (traj_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || result_ready) begin
      if (skid_valid) begin
        step_offset <= skid_step;
        lift_offset <= skid_lift;
      end else begin
        step_offset <= traj_step;
        lift_offset <= traj_lift;
      end
    end else if (traj_fire) begin
      skid_step <= traj_step;
      skid_lift <= traj_lift;
    end
  end

  assign step_limit  = signed'({1'b0, step_length});
  assign out_stalled = result_valid && !result_ready;
  assign step_ok     = (step_offset <= step_limit) && (step_offset >= -step_limit);

  `RGFT_ASSERT(a_skid_behind_out, clk, rst, skid_valid |-> result_valid)
  `RGFT_ASSERT(a_skid_fill_on_stall, clk, rst, $rose(skid_valid) |-> $past(out_stalled))
  `RGFT_ASSERT(a_step_in_range, clk, rst, result_valid |-> step_ok)
  `RGFT_NEVER(a_lift_over_peak, clk, rst, result_valid && (lift_offset > lift_height))

endmodule

`default_nettype wire
